// ===== rtl/cau_pkg.sv =====
`timescale 1ns / 1ps

package cau_pkg;

   localparam int WORD_BITS  = 32;
   localparam int FRAC_BITS  = 16;
   localparam int PROD_W     = 2 * WORD_BITS;
   localparam int SUM_W      = PROD_W + 2;
   localparam int MAG_W      = SUM_W - 1;
   localparam int NUM_W      = MAG_W + FRAC_BITS;
   localparam int DEN_W      = PROD_W;
   localparam int REM_W      = DEN_W + 1;
   localparam int CMP_W      = (NUM_W > DEN_W + WORD_BITS) ? NUM_W : DEN_W + WORD_BITS;
   localparam int DIV_STEPS  = 2;
   localparam int DIV_STAGES = WORD_BITS / DIV_STEPS;
   localparam int LATENCY    = DIV_STAGES + 5;

   typedef enum logic [2:0] {
      FUNC_ADD  = 3'd0,
      FUNC_SUB  = 3'd1,
      FUNC_MUL  = 3'd2,
      FUNC_DIV  = 3'd3,
      FUNC_CONJ = 3'd4,
      FUNC_NORM = 3'd5,
      FUNC_EQ   = 3'd6
   } func_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] val;
      logic                 clip;
   } sat_type;

   // per transaction control and non-divide result travelling down the pipe
   typedef struct packed {
      logic                 valid;
      logic [2:0]           func;
      logic [WORD_BITS-1:0] res_re;
      logic [WORD_BITS-1:0] res_im;
      logic                 eq;
      logic                 sat;
      logic                 neg_re;
      logic                 neg_im;
      logic                 ovf_re;
      logic                 ovf_im;
      logic                 dz;
   } meta_type;

   // one lane of the restoring divider
   typedef struct packed {
      logic [REM_W-1:0]     rem;
      logic [WORD_BITS-1:0] nlow;
      logic [WORD_BITS-1:0] q;
   } lane_type;

   // clip a wide signed value to the word range
   function automatic sat_type sat_word(input logic signed [SUM_W-1:0] x);
      sat_type                 r;
      logic signed [SUM_W-1:0] hi;
      logic signed [SUM_W-1:0] lo;
      hi = {{(SUM_W-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
      lo = ~hi;
      r.clip = 1'b0;
      r.val  = x[WORD_BITS-1:0];
      if (x > hi) begin
         r.clip = 1'b1;
         r.val  = {1'b0, {(WORD_BITS-1){1'b1}}};
      end else if (x < lo) begin
         r.clip = 1'b1;
         r.val  = {1'b1, {(WORD_BITS-1){1'b0}}};
      end
      return r;
   endfunction

   // apply sign to an unsigned quotient and clip
   function automatic sat_type quot_word(input logic [WORD_BITS-1:0] q,
                                         input logic neg, input logic ovf);
      sat_type r;
      r.clip = 1'b0;
      r.val  = q;
      if (ovf) begin
         r.clip = 1'b1;
         r.val  = neg ? {1'b1, {(WORD_BITS-1){1'b0}}} : {1'b0, {(WORD_BITS-1){1'b1}}};
      end else if (neg) begin
         if (q[WORD_BITS-1] && |q[WORD_BITS-2:0]) begin
            r.clip = 1'b1;
            r.val  = {1'b1, {(WORD_BITS-1){1'b0}}};
         end else begin
            r.val = -q;
         end
      end else if (q[WORD_BITS-1]) begin
         r.clip = 1'b1;
         r.val  = {1'b0, {(WORD_BITS-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

// ===== rtl/cau_front.sv =====
`timescale 1ns / 1ps

module cau_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   input  logic [2:0]                          in_func,
   input  logic signed [cau_pkg::WORD_BITS-1:0] in_a_re,
   input  logic signed [cau_pkg::WORD_BITS-1:0] in_a_im,
   input  logic signed [cau_pkg::WORD_BITS-1:0] in_b_re,
   input  logic signed [cau_pkg::WORD_BITS-1:0] in_b_im,
   output cau_pkg::meta_type                   meta,
   output logic [cau_pkg::NUM_W-1:0]           num_re,
   output logic [cau_pkg::NUM_W-1:0]           num_im,
   output logic [cau_pkg::DEN_W-1:0]           den
);
   import cau_pkg::*;

   logic                         v1_ff, v2_ff;
   logic [2:0]                   f1_ff, f2_ff;
   logic signed [WORD_BITS-1:0]  ar1_ff, ai1_ff, br1_ff, bi1_ff;
   logic signed [WORD_BITS-1:0]  ar2_ff, ai2_ff, br2_ff, bi2_ff;
   logic signed [PROD_W-1:0]     p0_ff, p1_ff, p2_ff, p3_ff, p4_ff, p5_ff;
   logic signed [WORD_BITS-1:0]  m0_b, m1_b;
   meta_type                     meta_ff, meta_in;
   logic [NUM_W-1:0]             num_re_ff, num_re_in, num_im_ff, num_im_in;
   logic [DEN_W-1:0]             den_ff, den_in;
   logic signed [SUM_W-1:0]      sum_re, sum_im, mag_re, mag_im;
   logic signed [SUM_W-1:0]      ear, eai, ebr, ebi;
   sat_type                      s_re, s_im;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
      end
      f1_ff  <= in_func;
      ar1_ff <= in_a_re;
      ai1_ff <= in_a_im;
      br1_ff <= in_b_re;
      bi1_ff <= in_b_im;
   end

   // squared norm reuses the first two multipliers
   assign m0_b = (f1_ff == FUNC_NORM) ? ar1_ff : br1_ff;
   assign m1_b = (f1_ff == FUNC_NORM) ? ai1_ff : bi1_ff;

   // product stage
   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      f2_ff  <= f1_ff;
      ar2_ff <= ar1_ff;
      ai2_ff <= ai1_ff;
      br2_ff <= br1_ff;
      bi2_ff <= bi1_ff;
      p0_ff  <= ar1_ff * m0_b;
      p1_ff  <= ai1_ff * m1_b;
      p2_ff  <= ai1_ff * br1_ff;
      p3_ff  <= ar1_ff * bi1_ff;
      p4_ff  <= br1_ff * br1_ff;
      p5_ff  <= bi1_ff * bi1_ff;
   end

   // sums, direct results and divider operands
   always_comb begin
      ear = SUM_W'(ar2_ff);
      eai = SUM_W'(ai2_ff);
      ebr = SUM_W'(br2_ff);
      ebi = SUM_W'(bi2_ff);
      if (f2_ff == FUNC_MUL) begin
         sum_re = SUM_W'(p0_ff) - SUM_W'(p1_ff);
         sum_im = SUM_W'(p2_ff) + SUM_W'(p3_ff);
      end else begin
         sum_re = SUM_W'(p0_ff) + SUM_W'(p1_ff);
         sum_im = SUM_W'(p2_ff) - SUM_W'(p3_ff);
      end
      s_re = '0;
      s_im = '0;
      meta_in       = '0;
      meta_in.valid = v2_ff;
      meta_in.func  = f2_ff;
      case (f2_ff)
         FUNC_ADD: begin
            s_re = sat_word(ear + ebr);
            s_im = sat_word(eai + ebi);
         end
         FUNC_SUB: begin
            s_re = sat_word(ear - ebr);
            s_im = sat_word(eai - ebi);
         end
         FUNC_MUL: begin
            s_re = sat_word(sum_re >>> FRAC_BITS);
            s_im = sat_word(sum_im >>> FRAC_BITS);
         end
         FUNC_CONJ: begin
            s_re = sat_word(ear);
            s_im = sat_word(-eai);
         end
         FUNC_NORM: begin
            s_re = sat_word(sum_re >>> FRAC_BITS);
         end
         FUNC_EQ: begin
            meta_in.eq = (ar2_ff == br2_ff) && (ai2_ff == bi2_ff);
         end
         default: begin
         end
      endcase
      meta_in.res_re = s_re.val;
      meta_in.res_im = s_im.val;
      meta_in.sat    = s_re.clip | s_im.clip;
      meta_in.neg_re = sum_re[SUM_W-1];
      meta_in.neg_im = sum_im[SUM_W-1];
      mag_re    = sum_re[SUM_W-1] ? -sum_re : sum_re;
      mag_im    = sum_im[SUM_W-1] ? -sum_im : sum_im;
      num_re_in = {mag_re[MAG_W-1:0], {FRAC_BITS{1'b0}}};
      num_im_in = {mag_im[MAG_W-1:0], {FRAC_BITS{1'b0}}};
      den_in    = DEN_W'($unsigned(p4_ff)) + DEN_W'($unsigned(p5_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         meta_ff.valid <= 1'b0;
      end else begin
         meta_ff.valid <= meta_in.valid;
      end
      meta_ff.func   <= meta_in.func;
      meta_ff.res_re <= meta_in.res_re;
      meta_ff.res_im <= meta_in.res_im;
      meta_ff.eq     <= meta_in.eq;
      meta_ff.sat    <= meta_in.sat;
      meta_ff.neg_re <= meta_in.neg_re;
      meta_ff.neg_im <= meta_in.neg_im;
      meta_ff.ovf_re <= meta_in.ovf_re;
      meta_ff.ovf_im <= meta_in.ovf_im;
      meta_ff.dz     <= meta_in.dz;
      num_re_ff      <= num_re_in;
      num_im_ff      <= num_im_in;
      den_ff         <= den_in;
   end

   assign meta   = meta_ff;
   assign num_re = num_re_ff;
   assign num_im = num_im_ff;
   assign den    = den_ff;

endmodule

// ===== rtl/cau_div_step.sv =====
`timescale 1ns / 1ps

module cau_div_step (
   input  logic                      clock,
   input  cau_pkg::lane_type         lane_d,
   input  logic [cau_pkg::DEN_W-1:0] den,
   output cau_pkg::lane_type         lane_q
);
   import cau_pkg::*;

   lane_type step_ff, step_in;

   // restoring division, two quotient bits per stage
   always_comb begin
      step_in = lane_d;
      for (int k = 0; k < DIV_STEPS; k++) begin
         step_in.rem  = {step_in.rem[REM_W-2:0], step_in.nlow[WORD_BITS-1]};
         step_in.nlow = {step_in.nlow[WORD_BITS-2:0], 1'b0};
         if (step_in.rem >= REM_W'(den)) begin
            step_in.rem = step_in.rem - REM_W'(den);
            step_in.q   = {step_in.q[WORD_BITS-2:0], 1'b1};
         end else begin
            step_in.q   = {step_in.q[WORD_BITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
   end

   assign lane_q = step_ff;

endmodule

// ===== rtl/complex_arithmetic_unit_core.sv =====
`timescale 1ns / 1ps
// path: input register, product stage, front output register, divider set-up register, divider stages, output register
// throughput: one transaction per cycle, busy stays low, the pipeline never stalls
// the divider gives two quotient bits per stage over 16 stages
// reset: synchronous, clears the valid bits of every stage; data needs no reset

module complex_arithmetic_unit_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [2:0]                           req_func,
   input  logic signed [cau_pkg::WORD_BITS-1:0] req_a_re,
   input  logic signed [cau_pkg::WORD_BITS-1:0] req_a_im,
   input  logic signed [cau_pkg::WORD_BITS-1:0] req_b_re,
   input  logic signed [cau_pkg::WORD_BITS-1:0] req_b_im,
   output logic                                 rsp_valid,
   output logic signed [cau_pkg::WORD_BITS-1:0] rsp_res_re,
   output logic signed [cau_pkg::WORD_BITS-1:0] rsp_res_im,
   output logic                                 rsp_equal_flag,
   output logic                                 rsp_div_zero,
   output logic                                 rsp_saturated
);
   import cau_pkg::*;

   meta_type             f_meta;
   logic [NUM_W-1:0]     f_num_re, f_num_im;
   logic [DEN_W-1:0]     f_den;
   meta_type             meta_ff [DIV_STAGES+1];
   logic [DEN_W-1:0]     den_ff  [DIV_STAGES+1];
   lane_type             lane_re [DIV_STAGES+1];
   lane_type             lane_im [DIV_STAGES+1];
   lane_type             lane_re_ff, lane_re_in, lane_im_ff, lane_im_in;
   meta_type             meta0_in;
   logic                 out_valid_ff;
   logic [WORD_BITS-1:0] out_re_ff, out_re_in, out_im_ff, out_im_in;
   logic                 out_eq_ff, out_eq_in, out_dz_ff, out_dz_in, out_sat_ff, out_sat_in;
   sat_type              q_re, q_im;
   meta_type             last;

   assign busy = 1'b0;

   // operand registers, products and sums
   cau_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (start & ~busy),
      .in_func  (req_func),
      .in_a_re  (req_a_re),
      .in_a_im  (req_a_im),
      .in_b_re  (req_b_re),
      .in_b_im  (req_b_im),
      .meta     (f_meta),
      .num_re   (f_num_re),
      .num_im   (f_num_im),
      .den      (f_den)
   );

   // quotient overflow check and divider set-up
   always_comb begin
      meta0_in        = f_meta;
      meta0_in.ovf_re = CMP_W'(f_num_re) >= CMP_W'({f_den, {WORD_BITS{1'b0}}});
      meta0_in.ovf_im = CMP_W'(f_num_im) >= CMP_W'({f_den, {WORD_BITS{1'b0}}});
      meta0_in.dz     = (f_meta.func == FUNC_DIV) && (f_den == '0);
      lane_re_in.rem  = REM_W'(f_num_re >> WORD_BITS);
      lane_re_in.nlow = f_num_re[WORD_BITS-1:0];
      lane_re_in.q    = '0;
      lane_im_in.rem  = REM_W'(f_num_im >> WORD_BITS);
      lane_im_in.nlow = f_num_im[WORD_BITS-1:0];
      lane_im_in.q    = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         meta_ff[0].valid <= 1'b0;
      end else begin
         meta_ff[0].valid <= meta0_in.valid;
      end
      meta_ff[0].func   <= meta0_in.func;
      meta_ff[0].res_re <= meta0_in.res_re;
      meta_ff[0].res_im <= meta0_in.res_im;
      meta_ff[0].eq     <= meta0_in.eq;
      meta_ff[0].sat    <= meta0_in.sat;
      meta_ff[0].neg_re <= meta0_in.neg_re;
      meta_ff[0].neg_im <= meta0_in.neg_im;
      meta_ff[0].ovf_re <= meta0_in.ovf_re;
      meta_ff[0].ovf_im <= meta0_in.ovf_im;
      meta_ff[0].dz     <= meta0_in.dz;
      den_ff[0]         <= f_den;
      lane_re_ff        <= lane_re_in;
      lane_im_ff        <= lane_im_in;
   end

   assign lane_re[0] = lane_re_ff;
   assign lane_im[0] = lane_im_ff;

   // divider stages with control carried alongside
   for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
      cau_div_step u_re (
         .clock  (clock),
         .lane_d (lane_re[j]),
         .den    (den_ff[j]),
         .lane_q (lane_re[j+1])
      );
      cau_div_step u_im (
         .clock  (clock),
         .lane_d (lane_im[j]),
         .den    (den_ff[j]),
         .lane_q (lane_im[j+1])
      );
      always_ff @(posedge clock) begin
         if (reset) begin
            meta_ff[j+1].valid <= 1'b0;
         end else begin
            meta_ff[j+1].valid <= meta_ff[j].valid;
         end
         meta_ff[j+1].func   <= meta_ff[j].func;
         meta_ff[j+1].res_re <= meta_ff[j].res_re;
         meta_ff[j+1].res_im <= meta_ff[j].res_im;
         meta_ff[j+1].eq     <= meta_ff[j].eq;
         meta_ff[j+1].sat    <= meta_ff[j].sat;
         meta_ff[j+1].neg_re <= meta_ff[j].neg_re;
         meta_ff[j+1].neg_im <= meta_ff[j].neg_im;
         meta_ff[j+1].ovf_re <= meta_ff[j].ovf_re;
         meta_ff[j+1].ovf_im <= meta_ff[j].ovf_im;
         meta_ff[j+1].dz     <= meta_ff[j].dz;
         den_ff[j+1]         <= den_ff[j];
      end
   end

   // result selection and output register
   always_comb begin
      last       = meta_ff[DIV_STAGES];
      q_re       = quot_word(lane_re[DIV_STAGES].q, last.neg_re, last.ovf_re);
      q_im       = quot_word(lane_im[DIV_STAGES].q, last.neg_im, last.ovf_im);
      out_re_in  = last.res_re;
      out_im_in  = last.res_im;
      out_eq_in  = last.eq;
      out_dz_in  = 1'b0;
      out_sat_in = last.sat;
      if (last.func == FUNC_DIV) begin
         if (last.dz) begin
            out_re_in  = '0;
            out_im_in  = '0;
            out_dz_in  = 1'b1;
            out_sat_in = 1'b0;
         end else begin
            out_re_in  = q_re.val;
            out_im_in  = q_im.val;
            out_sat_in = q_re.clip | q_im.clip;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= last.valid;
      end
      out_re_ff  <= out_re_in;
      out_im_ff  <= out_im_in;
      out_eq_ff  <= out_eq_in;
      out_dz_ff  <= out_dz_in;
      out_sat_ff <= out_sat_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_res_re     = out_re_ff;
   assign rsp_res_im     = out_im_ff;
   assign rsp_equal_flag = out_eq_ff;
   assign rsp_div_zero   = out_dz_ff;
   assign rsp_saturated  = out_sat_ff;

`ifndef SYNTHESIS
   // at most one status flag per transaction
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0({rsp_equal_flag, rsp_div_zero, rsp_saturated}))
      else $error("more than one status flag set");

   // divide by zero gives a zero result
   a_div_zero_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_div_zero |-> rsp_res_re == '0 && rsp_res_im == '0)
      else $error("divide by zero result not zero");

   // zero divisor at the divider output is always flagged
   a_dz_tracked: assert property (@(posedge clock) disable iff (reset)
      last.valid && last.func == FUNC_DIV && den_ff[DIV_STAGES] == '0 |=> rsp_div_zero)
      else $error("zero divisor not flagged");
`endif

endmodule

// ===== tb/complex_arithmetic_unit_core_tb.sv =====
`timescale 1ns / 1ps

module complex_arithmetic_unit_core_tb;
   import cau_pkg::*;

   typedef struct {
      logic [2:0]                  func;
      logic signed [WORD_BITS-1:0] a_re;
      logic signed [WORD_BITS-1:0] a_im;
      logic signed [WORD_BITS-1:0] b_re;
      logic signed [WORD_BITS-1:0] b_im;
      bit                          drain_first;
   } operation_type;

   typedef struct {
      logic signed [WORD_BITS-1:0] re;
      logic signed [WORD_BITS-1:0] im;
      logic                        eq;
      logic                        dz;
      logic                        sat;
   } answer_type;

   localparam logic signed [191:0] WORD_MAX = (192'sd1 <<< (WORD_BITS - 1)) - 192'sd1;
   localparam logic signed [191:0] WORD_MIN = -(192'sd1 <<< (WORD_BITS - 1));
   localparam logic [2:0] FUNC_UNUSED = 3'd7;
   localparam int STALL_LIMIT = 2000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic rsp_valid;
   logic signed [WORD_BITS-1:0] rsp_res_re, rsp_res_im;
   logic rsp_equal_flag, rsp_div_zero, rsp_saturated;

   operation_type pending_ops[$];
   answer_type    expected_answers[$];
   operation_type current_op = '{FUNC_ADD, 0, 0, 0, 0, 1'b0};
   bit            last_taken = 1'b0;
   int            sender_idle_pct = 0;
   int            mismatches = 0;
   int            quiet_cycles = 0;

   always #1 clock = ~clock;

   complex_arithmetic_unit_core DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_func(current_op.func), .req_a_re(current_op.a_re), .req_a_im(current_op.a_im),
      .req_b_re(current_op.b_re), .req_b_im(current_op.b_im),
      .rsp_valid(rsp_valid), .rsp_res_re(rsp_res_re), .rsp_res_im(rsp_res_im),
      .rsp_equal_flag(rsp_equal_flag), .rsp_div_zero(rsp_div_zero),
      .rsp_saturated(rsp_saturated)
   );

   // clip a wide value to the word, top bit flags clipping
   function automatic logic [WORD_BITS:0] clip_word(input logic signed [191:0] x);
      if (x > WORD_MAX) return {1'b1, WORD_MAX[WORD_BITS-1:0]};
      if (x < WORD_MIN) return {1'b1, WORD_MIN[WORD_BITS-1:0]};
      return {1'b0, x[WORD_BITS-1:0]};
   endfunction

   // exact complex arithmetic in a wide signed accumulator
   function automatic answer_type complex_result(input operation_type op);
      logic signed [191:0] ar, ai, br, bi, re, im, den;
      logic [WORD_BITS:0]  cre, cim;
      answer_type          r;
      ar = op.a_re;
      ai = op.a_im;
      br = op.b_re;
      bi = op.b_im;
      re = 0;
      im = 0;
      r.eq = 1'b0;
      r.dz = 1'b0;
      case (op.func)
         FUNC_ADD: begin
            re = ar + br;
            im = ai + bi;
         end
         FUNC_SUB: begin
            re = ar - br;
            im = ai - bi;
         end
         FUNC_MUL: begin
            re = (ar * br - ai * bi) >>> FRAC_BITS;
            im = (ai * br + ar * bi) >>> FRAC_BITS;
         end
         FUNC_DIV: begin
            den = br * br + bi * bi;
            if (den == 0) begin
               r.dz = 1'b1;
            end else begin
               re = ((ar * br + ai * bi) <<< FRAC_BITS) / den;
               im = ((ai * br - ar * bi) <<< FRAC_BITS) / den;
            end
         end
         FUNC_CONJ: begin
            re = ar;
            im = -ai;
         end
         FUNC_NORM: begin
            re = (ar * ar + ai * ai) >>> FRAC_BITS;
         end
         FUNC_EQ: begin
            r.eq = (ar == br) && (ai == bi);
         end
         default: ;
      endcase
      cre = clip_word(re);
      cim = clip_word(im);
      r.re  = cre[WORD_BITS-1:0];
      r.im  = cim[WORD_BITS-1:0];
      r.sat = cre[WORD_BITS] | cim[WORD_BITS];
      return r;
   endfunction

   task automatic report_mismatch(input string field, input logic [WORD_BITS-1:0] got,
                                  input logic [WORD_BITS-1:0] want);
      $display("mismatch on %s at %0t: got %h, expected %h", field, $realtime, got, want);
      mismatches++;
   endtask

   function automatic logic [WORD_BITS-1:0] pick_operand();
      case ($urandom_range(0, 5))
         0: case ($urandom_range(0, 5))
               0: return 32'h8000_0000;
               1: return 32'h7fff_ffff;
               2: return 32'h0000_0000;
               3: return 32'h0000_0001;
               4: return 32'hffff_ffff;
               default: return 32'h0001_0000;
            endcase
         1: return $urandom_range(0, 32'h3_ffff) - 32'h2_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic operation_type random_op();
      operation_type op;
      op.func = 3'($urandom_range(0, 7));
      op.a_re = pick_operand();
      op.a_im = pick_operand();
      op.b_re = pick_operand();
      op.b_im = ($urandom_range(0, 4) == 0) ? '0 : pick_operand();
      if (op.func == FUNC_EQ && $urandom_range(0, 1)) begin
         op.b_re = op.a_re;
         op.b_im = ($urandom_range(0, 2) == 0) ? op.a_im ^ 32'h1 : op.a_im;
      end
      if (op.func == FUNC_DIV && $urandom_range(0, 9) == 0) begin
         op.b_re = '0;
         op.b_im = '0;
      end
      op.drain_first = 1'b0;
      return op;
   endfunction

   task automatic add_op(input logic [2:0] f, input logic [31:0] ar, input logic [31:0] ai,
                         input logic [31:0] br, input logic [31:0] bi);
      pending_ops.push_back('{f, ar, ai, br, bi, 1'b0});
   endtask

   // driver: hold a transaction until taken, then maybe idle
   always @(negedge clock) begin
      logic go;
      go = start && !last_taken;
      if (!reset && !go && pending_ops.size() > 0
          && !(pending_ops[0].drain_first && expected_answers.size() > 0)
          && $urandom_range(0, 99) >= sender_idle_pct) begin
         current_op = pending_ops.pop_front();
         go = 1'b1;
      end
      start <= go;
   end

   // monitor: predict on acceptance, check on strobe
   always @(posedge clock) begin
      answer_type want;
      last_taken <= start && !busy && !reset;
      if (!reset) begin
         if (start && !busy) expected_answers.push_back(complex_result(current_op));
         if (rsp_valid) begin
            if (expected_answers.size() == 0) begin
               report_mismatch("unexpected result", rsp_res_re, '0);
            end else begin
               want = expected_answers.pop_front();
               if (rsp_res_re !== want.re) report_mismatch("res_re", rsp_res_re, want.re);
               if (rsp_res_im !== want.im) report_mismatch("res_im", rsp_res_im, want.im);
               if (rsp_equal_flag !== want.eq)
                  report_mismatch("equal_flag", 32'(rsp_equal_flag), 32'(want.eq));
               if (rsp_div_zero !== want.dz)
                  report_mismatch("div_zero", 32'(rsp_div_zero), 32'(want.dz));
               if (rsp_saturated !== want.sat)
                  report_mismatch("saturated", 32'(rsp_saturated), 32'(want.sat));
            end
         end
      end
   end

   // watchdog on cycles with no transaction either way
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      operation_type op;
      // directed corner cases
      add_op(FUNC_ADD, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 32'hffff_ffff);
      add_op(FUNC_ADD, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0000_0000);
      add_op(FUNC_SUB, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001, 32'hffff_ffff);
      add_op(FUNC_SUB, 32'h0005_0000, 32'hfffb_0000, 32'h0002_8000, 32'h0000_0000);
      add_op(FUNC_MUL, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 32'hffff_0000);
      add_op(FUNC_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      add_op(FUNC_MUL, 32'hffff_ffff, 32'h0000_0000, 32'h0000_0001, 32'h0000_0000);
      add_op(FUNC_MUL, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
      add_op(FUNC_DIV, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
      add_op(FUNC_DIV, 32'h0006_0000, 32'h0002_0000, 32'h0001_0000, 32'h0001_0000);
      add_op(FUNC_DIV, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 32'h0000_0000);
      add_op(FUNC_DIV, 32'hffff_ffff, 32'h0000_0001, 32'h0003_0000, 32'h0000_0000);
      add_op(FUNC_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      add_op(FUNC_CONJ, 32'h1234_5678, 32'h8000_0000, 32'h0, 32'h0);
      add_op(FUNC_CONJ, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h1);
      add_op(FUNC_NORM, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0);
      add_op(FUNC_NORM, 32'h0003_0000, 32'hfffc_0000, 32'h0, 32'h0);
      add_op(FUNC_NORM, 32'h0000_00ff, 32'h0000_0001, 32'h5, 32'h5);
      add_op(FUNC_EQ, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
      add_op(FUNC_EQ, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_fffe);
      add_op(FUNC_EQ, 32'h0000_0000, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001);
      add_op(FUNC_UNUSED, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // random phases with different sender gaps
      for (int k = 0; k < 4; k++) begin
         for (int n = 0; n < 290; n++) begin
            op = random_op();
            op.drain_first = (k == 2 && n == 0);
            pending_ops.push_back(op);
         end
         case (k)
            0: sender_idle_pct = 0;
            1: sender_idle_pct = 47;
            2: sender_idle_pct = 0;
            default: sender_idle_pct = 22;
         endcase
         while (pending_ops.size() > 0) @(posedge clock);
      end

      while (expected_answers.size() > 0 || start) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (mismatches == 0 && expected_answers.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/cau_pkg.sv
rtl/cau_front.sv
rtl/cau_div_step.sv
rtl/complex_arithmetic_unit_core.sv
tb/complex_arithmetic_unit_core_tb.sv
